FILE: hdl/ktc_pkg.sv
// Shared types, constants and the keyword ROM for the keyword tally counter.
// Used by every module under hdl; depends on nothing else.
package ktc_pkg;

  // Sizing
  localparam int NUM_WORDS    = 50;
  localparam int MAX_WORD_LEN = 8;
  localparam int COUNT_WIDTH  = 32;

  // Keyword ROM geometry
  localparam int ROM_WORDS    = 50;
  localparam int ROM_LEN      = 8;
  localparam int ROM_BITS     = ROM_LEN * 8;
  localparam int ROM_IDX_W    = 6;
  localparam int KLEN_W       = 4;
  localparam int SEARCH_WORDS = (NUM_WORDS < ROM_WORDS) ? NUM_WORDS : ROM_WORDS;

  // Derived widths
  localparam int WORD_BITS = MAX_WORD_LEN * 8;
  localparam int LEN_W     = $clog2(MAX_WORD_LEN + 2);
  localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BOUND_W   = $clog2(SEARCH_WORDS + 1);

  // Request function codes
  localparam logic [1:0] FUNC_TEXT  = 2'd0;
  localparam logic [1:0] FUNC_FLUSH = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [ROM_IDX_W-1:0]   rom_idx_t;
  typedef logic [IDX_W-1:0]       addr_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BOUND_W-1:0]     bound_t;

  // One keyword: bytes left-justified, first byte in the top bits, zero padded
  typedef struct packed {
    logic [ROM_BITS-1:0] bytes;
    logic [KLEN_W-1:0]   len;
  } kw_t;

  // Result of one probe of the comparator
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

  // Counter store request from the sequencer
  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    logic   clr;
    addr_t  addr;
    count_t wr_data;
  } mem_req_t;

  function automatic kw_t mk_kw(input logic [ROM_BITS-1:0] s, input int n);
    kw_t e;
    e.bytes = s << (8 * (ROM_LEN - n));
    e.len   = KLEN_W'(n);
    return e;
  endfunction

  // Keywords in unsigned byte order
  function automatic kw_t keyword_entry(input rom_idx_t k);
    kw_t e;
    case (k)
      6'd0:  e = mk_kw(ROM_BITS'("Alaska"), 6);
      6'd1:  e = mk_kw(ROM_BITS'("all"), 3);
      6'd2:  e = mk_kw(ROM_BITS'("and"), 3);
      6'd3:  e = mk_kw(ROM_BITS'("but"), 3);
      6'd4:  e = mk_kw(ROM_BITS'("coin"), 4);
      6'd5:  e = mk_kw(ROM_BITS'("color"), 5);
      6'd6:  e = mk_kw(ROM_BITS'("computer"), 8);
      6'd7:  e = mk_kw(ROM_BITS'("could"), 5);
      6'd8:  e = mk_kw(ROM_BITS'("dagger"), 6);
      6'd9:  e = mk_kw(ROM_BITS'("day"), 3);
      6'd10: e = mk_kw(ROM_BITS'("family"), 6);
      6'd11: e = mk_kw(ROM_BITS'("full"), 4);
      6'd12: e = mk_kw(ROM_BITS'("happy"), 5);
      6'd13: e = mk_kw(ROM_BITS'("have"), 4);
      6'd14: e = mk_kw(ROM_BITS'("her"), 3);
      6'd15: e = mk_kw(ROM_BITS'("his"), 3);
      6'd16: e = mk_kw(ROM_BITS'("i"), 1);
      6'd17: e = mk_kw(ROM_BITS'("ice"), 3);
      6'd18: e = mk_kw(ROM_BITS'("in"), 2);
      6'd19: e = mk_kw(ROM_BITS'("kill"), 4);
      6'd20: e = mk_kw(ROM_BITS'("knife"), 5);
      6'd21: e = mk_kw(ROM_BITS'("law"), 3);
      6'd22: e = mk_kw(ROM_BITS'("life"), 4);
      6'd23: e = mk_kw(ROM_BITS'("love"), 4);
      6'd24: e = mk_kw(ROM_BITS'("mama"), 4);
      6'd25: e = mk_kw(ROM_BITS'("man"), 3);
      6'd26: e = mk_kw(ROM_BITS'("most"), 4);
      6'd27: e = mk_kw(ROM_BITS'("murder"), 6);
      6'd28: e = mk_kw(ROM_BITS'("name"), 4);
      6'd29: e = mk_kw(ROM_BITS'("not"), 3);
      6'd30: e = mk_kw(ROM_BITS'("of"), 2);
      6'd31: e = mk_kw(ROM_BITS'("our"), 3);
      6'd32: e = mk_kw(ROM_BITS'("phone"), 5);
      6'd33: e = mk_kw(ROM_BITS'("pie"), 3);
      6'd34: e = mk_kw(ROM_BITS'("pizza"), 5);
      6'd35: e = mk_kw(ROM_BITS'("question"), 8);
      6'd36: e = mk_kw(ROM_BITS'("rock"), 4);
      6'd37: e = mk_kw(ROM_BITS'("snake"), 5);
      6'd38: e = mk_kw(ROM_BITS'("so"), 2);
      6'd39: e = mk_kw(ROM_BITS'("soda"), 4);
      6'd40: e = mk_kw(ROM_BITS'("still"), 5);
      6'd41: e = mk_kw(ROM_BITS'("stopped"), 7);
      6'd42: e = mk_kw(ROM_BITS'("tape"), 4);
      6'd43: e = mk_kw(ROM_BITS'("teeth"), 5);
      6'd44: e = mk_kw(ROM_BITS'("the"), 3);
      6'd45: e = mk_kw(ROM_BITS'("those"), 5);
      6'd46: e = mk_kw(ROM_BITS'("was"), 3);
      6'd47: e = mk_kw(ROM_BITS'("word"), 4);
      6'd48: e = mk_kw(ROM_BITS'("young"), 5);
      6'd49: e = mk_kw(ROM_BITS'("zebra"), 5);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: hdl/ktc_compare.sv
// Shared comparator: orders the pending word against one ROM keyword.
// Depends on ktc_pkg for the ROM and the result type.
module ktc_compare (
  input  logic [ktc_pkg::WORD_BITS-1:0] word,
  input  ktc_pkg::len_t                 word_len,
  input  ktc_pkg::rom_idx_t             probe,
  output ktc_pkg::cmp_t                 result
);
  import ktc_pkg::*;

  kw_t                 kw;
  logic [WORD_BITS-1:0] kw_w;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] b;
  int                  wlen;
  int                  klen;
  int                  n;

  always_comb begin
    kw   = keyword_entry(probe);
    wlen = int'(word_len);
    klen = int'(kw.len);
    n    = (wlen < klen) ? wlen : klen;
    // Align the keyword to the word store and keep only the common prefix
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      if (i < ROM_LEN) begin
        kw_w[WORD_BITS-1-8*i -: 8] = kw.bytes[ROM_BITS-1-8*i -: 8];
      end else begin
        kw_w[WORD_BITS-1-8*i -: 8] = 8'h00;
      end
      mask[WORD_BITS-1-8*i -: 8] = (i < n) ? 8'hFF : 8'h00;
    end
    a = word & mask;
    b = kw_w & mask;
    // First differing byte decides; on a common prefix the shorter is lower
    if (a != b) begin
      result.eq = 1'b0;
      result.lt = (a < b);
    end else begin
      result.eq = (wlen == klen);
      result.lt = (wlen < klen);
    end
  end

endmodule

FILE: hdl/ktc_count_mem.sv
// Counter store: one read port with registered data, one write port, and
// per-entry valid bits so a clear zeroes every entry at once. Depends on ktc_pkg.
module ktc_count_mem (
  input  logic              clk,
  input  logic              rst,
  input  ktc_pkg::mem_req_t req,
  output ktc_pkg::count_t   rd_data
);
  import ktc_pkg::*;

  count_t                 mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]   valid;

  // Valid bits: reset and clear zero every counter at once
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.addr] <= 1'b1;
    end
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
  end

  // Registered read; an entry not written since the last clear reads zero
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= valid[req.addr] ? mem[req.addr] : '0;
    end
  end

endmodule

FILE: hdl/keyword_tally_counter.sv
// Keyword tally counter: one request at a time through one shared comparator.
// A byte or a clear goes straight to its result, a counter read fetches the counter first,
// and a word end binary-searches the keyword ROM until a match or an empty range.
// A hit adds a counter fetch and a write-back after the probe that matched.
// The next request is taken only once the result is loaded and the sequencer is idle again;
// an output stall holds this off. Reset clears counters and the word.
module keyword_tally_counter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] char_code,
  input  logic [5:0] word_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic [5:0] match_index,
  output logic [31:0] count_value
);
  import ktc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_FETCH  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] word_buf;
  len_t                 word_len;
  bound_t               lo;
  bound_t               hi_ex;
  logic [BOUND_W:0]     mid_sum;
  bound_t               mid;
  logic                 is_read;
  logic                 hit;
  rom_idx_t             hit_idx;
  addr_t                addr;
  logic [31:0]          count_res;
  logic                 clr_pulse;
  logic                 in_accept;
  logic                 is_ws;
  logic                 word_ok;
  cmp_t                 cmp;
  mem_req_t             mem_req;
  count_t               rd_data;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_ws     = ((char_code >= 8'd9) && (char_code <= 8'd13)) || (char_code == 8'd32);
  assign word_ok   = (word_len != '0) && (int'(word_len) <= MAX_WORD_LEN);
  assign mid_sum   = {1'b0, lo} + {1'b0, hi_ex};
  assign mid       = mid_sum[BOUND_W:1];

  // Shared comparator, probed at the midpoint each search cycle
  ktc_compare u_cmp (
    .word     (word_buf),
    .word_len (word_len),
    .probe    (ROM_IDX_W'(mid)),
    .result   (cmp)
  );

  ktc_count_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Counter store requests
  always_comb begin
    mem_req.rd_en   = (state == S_FETCH);
    mem_req.wr_en   = (state == S_UPDATE) && !is_read;
    mem_req.clr     = clr_pulse;
    mem_req.addr    = addr;
    mem_req.wr_data = (rd_data == '1) ? rd_data : rd_data + COUNT_WIDTH'(1);
  end

  // Pending word bytes: no reset, only bytes below the length are ever compared
  always_ff @(posedge clk) begin
    if (in_accept && (func == FUNC_TEXT) && !is_ws && (int'(word_len) < MAX_WORD_LEN)) begin
      for (int i = 0; i < MAX_WORD_LEN; i++) begin
        if (int'(word_len) == i) begin
          word_buf[WORD_BITS-1-8*i -: 8] <= char_code;
        end
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      word_len  <= '0;
      clr_pulse <= 1'b0;
      out_valid <= 1'b0;
      lo        <= '0;
      hi_ex     <= '0;
      is_read   <= 1'b0;
      hit       <= 1'b0;
      hit_idx   <= '0;
      addr      <= '0;
      count_res <= '0;
    end else begin
      // One-cycle clear after an accepted clear request
      clr_pulse <= in_accept && (func == FUNC_CLEAR);
      // Result valid: set as the output register loads, dropped once taken
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            is_read   <= (func == FUNC_READ);
            hit       <= 1'b0;
            hit_idx   <= '0;
            count_res <= '0;
            lo        <= '0;
            hi_ex     <= BOUND_W'(SEARCH_WORDS);
            unique case (func) inside
              FUNC_TEXT, FUNC_FLUSH: begin
                if ((func == FUNC_TEXT) && !is_ws) begin
                  // Append or mark the word as too long
                  if (int'(word_len) < MAX_WORD_LEN) begin
                    word_len <= word_len + len_t'(1);
                  end else begin
                    word_len <= len_t'(MAX_WORD_LEN + 1);
                  end
                  state <= S_DONE;
                end else if (word_ok) begin
                  state <= S_SEARCH;
                end else begin
                  word_len <= '0;
                  state    <= S_DONE;
                end
              end
              FUNC_READ: begin
                if (int'(word_index) < NUM_WORDS) begin
                  addr  <= IDX_W'(word_index);
                  state <= S_FETCH;
                end else begin
                  state <= S_DONE;
                end
              end
              FUNC_CLEAR: begin
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SEARCH: begin
          // One probe per cycle; an empty range is a miss
          if (lo >= hi_ex) begin
            word_len <= '0;
            state    <= S_DONE;
          end else if (cmp.eq) begin
            hit      <= 1'b1;
            hit_idx  <= ROM_IDX_W'(mid);
            addr     <= IDX_W'(mid);
            word_len <= '0;
            state    <= S_FETCH;
          end else if (cmp.lt) begin
            hi_ex <= mid;
          end else begin
            lo <= mid + bound_t'(1);
          end
        end
        S_FETCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          // Read data is here: report it, or write the bumped count back
          if (is_read) begin
            count_res <= 32'(rd_data);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      matched     <= hit;
      match_index <= 6'(hit_idx);
      count_value <= count_res;
    end
  end

  // A hit never carries a counter value
  a_hit_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> count_value == '0)
    else $error("matched result carries a counter value");

  // The index is zero unless the word matched
  a_miss_zero_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> match_index == '0)
    else $error("nonzero match_index without a match");

  // The search range never inverts
  a_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> lo <= hi_ex)
    else $error("binary search bounds crossed");

  // A counter write only follows a keyword hit
  a_write_on_hit: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> hit && !is_read)
    else $error("counter written without a hit");

  // Leaving the search clears the pending word
  a_word_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH && (lo >= hi_ex || cmp.eq) |=> word_len == '0)
    else $error("word length not cleared at word end");

endmodule

FILE: verif/keyword_tally_counter_tb.sv
// Self-checking testbench for keyword_tally_counter: directed requests from a table,
// then random text streams, checked against a keyword tally predictor.
// Depends on hdl/ktc_pkg.sv and hdl/keyword_tally_counter.sv.
module keyword_tally_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ktc_pkg::*;

  localparam int TOTAL_ITEMS = 1975;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  // Whitespace codes that end a word
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef struct packed {
    logic         matched;
    logic [5:0]   match_index;
    logic [31:0]  count_value;
  } tally_result_t;

  localparam tally_result_t ZERO_RESULT = '0;

  typedef struct packed {
    logic [1:0]    func;
    logic [7:0]    ch;
    logic [5:0]    widx;
    bit            typed;
    tally_result_t want;
  } step_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_TEXT;
  logic [7:0]  char_code = 8'd0;
  logic [5:0]  word_index = 6'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        matched;
  logic [5:0]  match_index;
  logic [31:0] count_value;

  keyword_tally_counter u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .char_code   (char_code),
    .word_index  (word_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .matched     (matched),
    .match_index (match_index),
    .count_value (count_value)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Keywords in unsigned byte order
  string kw_text [ROM_WORDS] = '{
    "Alaska", "all", "and", "but", "coin", "color", "computer", "could",
    "dagger", "day", "family", "full", "happy", "have", "her", "his",
    "i", "ice", "in", "kill", "knife", "law", "life", "love",
    "mama", "man", "most", "murder", "name", "not", "of", "our",
    "phone", "pie", "pizza", "question", "rock", "snake", "so", "soda",
    "still", "stopped", "tape", "teeth", "the", "those", "was", "word",
    "young", "zebra"
  };

  logic [7:0] ws_codes [6] = '{CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE};

  // Directed requests; typed expectations only where obvious
  step_row_t directed_rows [25] = '{
    '{FUNC_READ,  8'h00,    6'd0,  1'b1, ZERO_RESULT},
    '{FUNC_READ,  8'hFF,    6'd63, 1'b1, ZERO_RESULT},
    '{FUNC_FLUSH, 8'h00,    6'd49, 1'b1, ZERO_RESULT},
    '{FUNC_TEXT,  CH_SPACE, 6'd0,  1'b1, ZERO_RESULT},
    '{FUNC_TEXT,  "i",      6'd63, 1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  CH_LF,    6'd5,  1'b1, '{1'b1, 6'd16, 32'd0}},
    '{FUNC_TEXT,  "A",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "l",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "a",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "s",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "k",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "a",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_FLUSH, 8'hFF,    6'd63, 1'b1, '{1'b1, 6'd0, 32'd0}},
    '{FUNC_TEXT,  "c",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "o",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "m",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "p",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "u",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "t",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "e",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  "r",      6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  8'hFF,    6'd0,  1'b0, ZERO_RESULT},
    '{FUNC_TEXT,  CH_VT,    6'd0,  1'b1, ZERO_RESULT},
    '{FUNC_CLEAR, 8'h00,    6'd0,  1'b1, ZERO_RESULT},
    '{FUNC_READ,  8'h5A,    6'd16, 1'b1, ZERO_RESULT}
  };

  // Predictor state: pending word and keyword tallies
  logic [7:0]    pend_bytes [MAX_WORD_LEN];
  int            pend_len = 0;
  count_t        tally [NUM_WORDS] = '{default: '0};

  tally_result_t results_due [$];
  int            mismatches = 0;
  int            items_sent = 0;
  int            hold_asked = 0;
  bit            idle_on = 1'b1;

  function automatic bit is_space(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  // Exact, case-sensitive match of the pending word; -1 when none
  function automatic int lookup_keyword();
    int k;
    int i;
    bit same;
    for (k = 0; k < SEARCH_WORDS; k++) begin
      if (kw_text[k].len() == pend_len) begin
        same = 1'b1;
        for (i = 0; i < pend_len; i++)
          if (kw_text[k][i] != pend_bytes[i]) same = 1'b0;
        if (same) return k;
      end
    end
    return -1;
  endfunction

  function automatic tally_result_t finish_word();
    tally_result_t r;
    int k;
    r = '0;
    if (pend_len >= 1 && pend_len <= MAX_WORD_LEN) begin
      k = lookup_keyword();
      if (k >= 0) begin
        r.matched     = 1'b1;
        r.match_index = 6'(k);
        if (tally[k] != '1) tally[k] = tally[k] + 1'b1;
      end
    end
    pend_len = 0;
    return r;
  endfunction

  function automatic tally_result_t tally_step(input logic [1:0] f, input logic [7:0] c,
                                               input logic [5:0] w);
    tally_result_t r;
    r = '0;
    case (f)
      FUNC_TEXT: begin
        if (is_space(c)) begin
          r = finish_word();
        end else if (pend_len < MAX_WORD_LEN) begin
          pend_bytes[pend_len] = c;
          pend_len++;
        end else begin
          pend_len = MAX_WORD_LEN + 1;
        end
      end
      FUNC_FLUSH: r = finish_word();
      FUNC_READ: begin
        if (w < NUM_WORDS) r.count_value = 32'(tally[w]);
      end
      FUNC_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
      end
    endcase
    return r;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [5:0] pick_index();
    if ($urandom_range(0, 99) < 85) return 6'($urandom_range(0, NUM_WORDS - 1));
    return 6'($urandom_range(NUM_WORDS, 63));
  endfunction

  // Offer one request, wait for acceptance, then record what it should return
  task automatic send_request(input logic [1:0] f, input logic [7:0] c, input logic [5:0] w,
                              input bit typed = 1'b0, input tally_result_t want = '0);
    int gap;
    tally_result_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    char_code  <= c;
    word_index <= w;
    do @(posedge clk); while (in_stall);
    predicted = tally_step(f, c, w);
    results_due.insert(results_due.size(), typed ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    tally_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: matched=%0d index=%0d count=%0d",
                   matched, match_index, count_value);
      end else begin
        due = results_due.pop_front();
        if (matched !== due.matched || match_index !== due.match_index ||
            count_value !== due.count_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected matched=%0d index=%0d count=%0d, got %0d %0d %0d",
                     due.matched, due.match_index, due.count_value,
                     matched, match_index, count_value);
        end
      end
    end
  end

  // Output back-pressure: random stalls plus one long hold-off on request
  initial begin : result_pacing
    int n;
    int served;
    served = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != served) begin
        served = hold_asked;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    int k;
    int p;
    int n;
    int i;
    bit held;
    bit drained;
    logic [7:0] letters [$];
    held = 1'b0;
    drained = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[j])
      send_request(directed_rows[j].func, directed_rows[j].ch, directed_rows[j].widx,
                   directed_rows[j].typed, directed_rows[j].want);

    // Random words: mostly keywords and near misses, some noise
    while (items_sent < TOTAL_ITEMS) begin
      if (!held && items_sent >= 600) begin
        hold_asked++;
        held = 1'b1;
      end
      if (!drained && items_sent >= 1300) begin
        wait_results_drained();
        drained = 1'b1;
      end
      idle_on = (items_sent < 850 || items_sent >= 1050);

      letters.delete();
      r = $urandom_range(0, 99);
      k = $urandom_range(0, SEARCH_WORDS - 1);
      if (r < 80)
        for (i = 0; i < kw_text[k].len(); i++) letters.insert(letters.size(), kw_text[k][i]);
      if (r >= 50 && r < 58) begin
        // one byte off: case flip or another letter
        p = $urandom_range(0, letters.size() - 1);
        if (r < 54) letters[p] = letters[p] ^ 8'h20;
        else letters[p] = 8'($urandom_range(97, 122));
      end else if (r >= 58 && r < 66) begin
        if (letters.size() > 1) letters.delete(letters.size() - 1);
        else letters.insert(letters.size(), 8'($urandom_range(97, 122)));
      end else if (r >= 66 && r < 80) begin
        // keyword with a tail, often too long to match
        n = (r < 73) ? 1 : $urandom_range(2, 5);
        repeat (n) letters.insert(letters.size(), 8'($urandom_range(97, 122)));
      end else if (r >= 80 && r < 90) begin
        n = $urandom_range(1, 12);
        repeat (n) letters.insert(letters.size(), 8'($urandom_range(97, 122)));
      end else if (r >= 90) begin
        n = $urandom_range(1, 10);
        repeat (n) letters.insert(letters.size(), 8'($urandom_range(0, 255)));
      end

      // reads in mid-word must leave the pending word alone
      foreach (letters[j]) begin
        if ($urandom_range(0, 99) < 4)
          send_request(FUNC_READ, 8'($urandom_range(0, 255)), pick_index());
        send_request(FUNC_TEXT, letters[j], 6'($urandom_range(0, 63)));
      end
      if ($urandom_range(0, 99) < 80)
        send_request(FUNC_TEXT, ws_codes[$urandom_range(0, 5)], 6'($urandom_range(0, 63)));
      else
        send_request(FUNC_FLUSH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));

      // between words: empty word ends, reads, rare clears
      r = $urandom_range(0, 99);
      if (r < 7)
        send_request(FUNC_TEXT, ws_codes[$urandom_range(0, 5)], 6'($urandom_range(0, 63)));
      else if (r < 10)
        send_request(FUNC_FLUSH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      else if (r < 25)
        send_request(FUNC_READ, 8'($urandom_range(0, 255)), pick_index());
      else if (r < 26)
        send_request(FUNC_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
